// ===== rtl/core/segment_signature_average_table_defines.svh =====
// assertion macros for the segment signature table
// used by the top level only
`ifndef SEGMENT_SIGNATURE_AVERAGE_TABLE_DEFINES_SVH
`define SEGMENT_SIGNATURE_AVERAGE_TABLE_DEFINES_SVH
`define SSAT_ASSERT_IMPL(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("%m: check failed");
`define SSAT_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("%m: check failed");
`endif

// ===== rtl/core/ssat_pkg.sv =====
// shared types and constants for the segment signature table
// no dependencies
package ssat_pkg;
  localparam int NodeSlotsDef = 64;
  localparam int IdxW = 6;
  localparam int CntW = 16;
  localparam logic [CntW-1:0] CountMax = 16'hFFFF;
  localparam logic [15:0] KeepReset = 16'h8000;
  localparam int NumW = 45;
  localparam int DivSteps = 29;

  typedef enum logic [1:0] {
    KIND_UPDATE = 2'd0,
    KIND_KEPT = 2'd1,
    KIND_EMPTY = 2'd2
  } kind_t;

  typedef struct packed {
    logic grow_step;
    logic load_upd;
    logic upd_rd;
    logic div_start;
    logic div_step;
    logic div_write;
    logic scan_clr;
    logic scan_rd;
    logic scan_max;
    logic scan_keep;
    logic out_load;
    logic [1:0] out_kind;
    logic out_last;
    logic size_load;
  } cmd_t;

  typedef struct packed {
    logic grow_done;
    logic in_range;
    logic div_done;
    logic keep_hit;
  } sts_t;
endpackage

// ===== rtl/core/ssat_ctrl.sv =====
// controller state machine of the segment signature table
// depends on ssat_pkg
module ssat_ctrl #(
  parameter int NODE_SLOTS = ssat_pkg::NodeSlotsDef
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  logic in_op,
  input  logic in_present,
  input  logic out_ready,
  output logic out_valid,
  input  logic [6:0] size,
  input  ssat_pkg::sts_t sts,
  output ssat_pkg::cmd_t cmd,
  output logic [5:0] addr
);
  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_GROW  = 10'b0000000010,
    S_RD    = 10'b0000000100,
    S_DIV   = 10'b0000001000,
    S_EMIT  = 10'b0000010000,
    S_MAXRD = 10'b0000100000,
    S_MAX   = 10'b0001000000,
    S_KRD   = 10'b0010000000,
    S_KEEP  = 10'b0100000000,
    S_LIST  = 10'b1000000000
  } state_t;
  state_t state_r, state_nxt;
  logic [6:0] i_r, i_nxt, n_r, n_nxt;
  logic pres_r, pres_nxt, ov_r, ov_nxt, lrd_r, lrd_nxt;

  assign in_ready = (state_r == S_IDLE) && !ov_r;
  assign out_valid = ov_r;

  always_comb begin
    state_nxt = state_r; i_nxt = i_r; n_nxt = n_r; pres_nxt = pres_r;
    ov_nxt = ov_r && !out_ready; lrd_nxt = 1'b0;
    cmd = '0; addr = i_r[5:0];
    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          if (!in_op) begin
            cmd.load_upd = 1'b1; pres_nxt = in_present; state_nxt = S_GROW;
          end else if (size == 7'd0) begin
            cmd.out_load = 1'b1; cmd.out_kind = ssat_pkg::KIND_EMPTY;
            cmd.out_last = 1'b1; ov_nxt = 1'b1;
          end else begin
            cmd.scan_clr = 1'b1; i_nxt = '0; state_nxt = S_MAXRD;
          end
        end
      end
      S_GROW: begin
        if (!sts.in_range) state_nxt = S_IDLE;
        else if (!sts.grow_done) cmd.grow_step = 1'b1;
        else state_nxt = S_RD;
      end
      S_RD: begin
        cmd.upd_rd = 1'b1;
        if (pres_r) begin
          cmd.div_start = 1'b1; state_nxt = S_DIV;
        end else state_nxt = S_EMIT;
      end
      S_DIV: begin
        if (sts.div_done) begin
          cmd.div_write = 1'b1; state_nxt = S_EMIT;
        end else cmd.div_step = 1'b1;
      end
      S_EMIT: begin
        if (!ov_r) begin
          cmd.out_load = 1'b1; cmd.out_kind = ssat_pkg::KIND_UPDATE;
          cmd.out_last = 1'b1; ov_nxt = 1'b1; state_nxt = S_IDLE;
        end
      end
      S_MAXRD: begin
        cmd.scan_rd = 1'b1; state_nxt = S_MAX;
      end
      S_MAX: begin
        cmd.scan_max = 1'b1;
        if (i_r + 7'd1 >= size) begin
          i_nxt = '0; n_nxt = '0; state_nxt = S_KRD;
        end else begin
          i_nxt = i_r + 7'd1; state_nxt = S_MAXRD;
        end
      end
      S_KRD: begin
        cmd.scan_rd = 1'b1; state_nxt = S_KEEP;
      end
      S_KEEP: begin
        addr = n_r[5:0];
        if (sts.keep_hit) begin
          cmd.scan_keep = 1'b1; n_nxt = n_r + 7'd1;
        end
        if (i_r + 7'd1 >= size) begin
          cmd.size_load = 1'b1; i_nxt = '0; state_nxt = S_LIST;
        end else begin
          i_nxt = i_r + 7'd1; state_nxt = S_KRD;
        end
      end
      S_LIST: begin
        if (!lrd_r) begin
          cmd.scan_rd = 1'b1; lrd_nxt = 1'b1;
        end else if (!ov_r) begin
          cmd.out_load = 1'b1; cmd.out_kind = ssat_pkg::KIND_KEPT;
          cmd.out_last = (i_r + 7'd1 == n_r); ov_nxt = 1'b1;
          i_nxt = i_r + 7'd1;
          if (i_r + 7'd1 == n_r) state_nxt = S_IDLE;
        end else lrd_nxt = 1'b1;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; ov_r <= 1'b0; lrd_r <= 1'b0;
      i_r <= '0; n_r <= '0; pres_r <= 1'b0;
    end else begin
      state_r <= state_nxt; ov_r <= ov_nxt; lrd_r <= lrd_nxt;
      i_r <= i_nxt; n_r <= n_nxt; pres_r <= pres_nxt;
    end
  end
endmodule

// ===== rtl/core/ssat_dp.sv =====
// datapath of the segment signature table: stores, divider, prune compare
// depends on ssat_pkg
module ssat_dp #(
  parameter int NODE_SLOTS = ssat_pkg::NodeSlotsDef
) (
  input  logic clk,
  input  logic rst_n,
  input  ssat_pkg::cmd_t cmd,
  output ssat_pkg::sts_t sts,
  input  logic [5:0] addr,
  output logic [6:0] size,
  input  logic [15:0] keep_fraction,
  input  logic [5:0] in_node_index,
  input  logic [19:0] in_seg_area,
  input  logic [7:0] in_seg_red,
  input  logic [7:0] in_seg_green,
  input  logic [7:0] in_seg_blue,
  input  logic [11:0] in_seg_center_x,
  input  logic [11:0] in_seg_center_y,
  output logic [1:0] out_kind,
  output logic [5:0] out_slot,
  output logic [15:0] out_seen_count,
  output logic [27:0] out_avg_area,
  output logic [15:0] out_avg_red,
  output logic [15:0] out_avg_green,
  output logic [15:0] out_avg_blue,
  output logic [19:0] out_avg_center_x,
  output logic [19:0] out_avg_center_y,
  output logic out_last
);
  localparam int EW = 132;
  logic [EW-1:0] mem [NODE_SLOTS];
  logic [EW-1:0] rd_r;
  logic [6:0] size_r, gsz_r;
  logic [6:0] keep_n_r;
  logic [5:0] idx_r, rpt_r;
  logic [19:0] va_r;
  logic [7:0] vr_r, vg_r, vb_r;
  logic [11:0] vx_r, vy_r;
  logic [15:0] longest_r;
  logic [4:0] step_r;
  logic [5:0] slot_ix;
  logic [ssat_pkg::NumW-1:0] num_r [6];
  logic [ssat_pkg::NumW-1:0] rem_r [6];
  logic [27:0] q_r [6];
  logic [16:0] dvs;
  logic [31:0] thr;
  logic [31:0] cshift;
  logic [EW-1:0] wr_data;
  logic [5:0] rd_addr;
  logic [ssat_pkg::NumW-1:0] num_init [6];
  logic [19:0] vext [6];
  logic [27:0] sval [6];

  assign size = size_r;
  assign dvs = {1'b0, rd_r[EW-1 -: 16]} + 17'd1;
  assign sts.in_range = {1'b0, idx_r} < 7'(NODE_SLOTS);
  assign sts.grow_done = gsz_r > {1'b0, idx_r};
  assign sts.div_done = step_r == 5'(ssat_pkg::DivSteps);
  assign thr = 32'(longest_r) * 32'(keep_fraction);
  assign cshift = {rd_r[EW-1 -: 16], 16'd0};
  assign sts.keep_hit = cshift >= thr;

  assign sval[0] = rd_r[115:88];
  assign sval[1] = {12'd0, rd_r[87:72]};
  assign sval[2] = {12'd0, rd_r[71:56]};
  assign sval[3] = {12'd0, rd_r[55:40]};
  assign sval[4] = {8'd0, rd_r[39:20]};
  assign sval[5] = {8'd0, rd_r[19:0]};
  assign vext[0] = va_r;
  assign vext[1] = {12'd0, vr_r};
  assign vext[2] = {12'd0, vg_r};
  assign vext[3] = {12'd0, vb_r};
  assign vext[4] = {8'd0, vx_r};
  assign vext[5] = {8'd0, vy_r};

  always_comb begin
    for (int k = 0; k < 6; k++)
      num_init[k] = 45'(sval[k]) * 45'(rd_r[EW-1 -: 16]) + 45'({vext[k], 8'd0});
  end

  assign wr_data = {(rd_r[EW-1 -: 16] == ssat_pkg::CountMax) ? ssat_pkg::CountMax
                    : rd_r[EW-1 -: 16] + 16'd1,
                    q_r[0], q_r[1][15:0], q_r[2][15:0], q_r[3][15:0],
                    q_r[4][19:0], q_r[5][19:0]};

  always_comb begin
    rd_addr = idx_r;
    if (cmd.scan_rd) rd_addr = addr;
  end
  assign slot_ix = rpt_r;

  always_ff @(posedge clk) begin
    if (cmd.scan_rd || cmd.upd_rd) rd_r <= mem[rd_addr];
    else if (cmd.div_write) rd_r <= wr_data;
    if (cmd.grow_step) mem[gsz_r[5:0]] <= '0;
    else if (cmd.div_write) mem[idx_r] <= wr_data;
    else if (cmd.scan_keep) mem[addr] <= rd_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_upd) begin
      idx_r <= in_node_index; va_r <= in_seg_area; vr_r <= in_seg_red;
      vg_r <= in_seg_green; vb_r <= in_seg_blue;
      vx_r <= in_seg_center_x; vy_r <= in_seg_center_y;
    end
    if (cmd.div_start) step_r <= '0;
    else if (cmd.div_step) step_r <= step_r + 5'd1;
    if (cmd.scan_rd) rpt_r <= addr;
    for (int k = 0; k < 6; k++) begin
      if (cmd.div_step && step_r == 5'd0) begin
        num_r[k] <= num_init[k] << (ssat_pkg::NumW - 28);
        rem_r[k] <= num_init[k] >> 28;
        q_r[k] <= '0;
      end else if (cmd.div_step) begin
        logic [ssat_pkg::NumW:0] tr;
        tr = {rem_r[k], num_r[k][ssat_pkg::NumW-1]};
        num_r[k] <= num_r[k] << 1;
        if (tr >= (ssat_pkg::NumW+1)'(dvs)) begin
          rem_r[k] <= ssat_pkg::NumW'(tr - (ssat_pkg::NumW+1)'(dvs));
          q_r[k] <= {q_r[k][26:0], 1'b1};
        end else begin
          rem_r[k] <= ssat_pkg::NumW'(tr);
          q_r[k] <= {q_r[k][26:0], 1'b0};
        end
      end
    end
    if (cmd.scan_clr) longest_r <= '0;
    else if (cmd.scan_max && rd_r[EW-1 -: 16] > longest_r) longest_r <= rd_r[EW-1 -: 16];
    if (cmd.out_load) begin
      out_kind <= cmd.out_kind;
      out_last <= cmd.out_last;
      if (cmd.out_kind == ssat_pkg::KIND_EMPTY) begin
        out_slot <= '0; {out_seen_count, out_avg_area, out_avg_red, out_avg_green,
          out_avg_blue, out_avg_center_x, out_avg_center_y} <= '0;
      end else begin
        out_slot <= (cmd.out_kind == ssat_pkg::KIND_UPDATE) ? idx_r : slot_ix;
        {out_seen_count, out_avg_area, out_avg_red, out_avg_green,
          out_avg_blue, out_avg_center_x, out_avg_center_y} <= rd_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= '0; gsz_r <= '0;
    end else begin
      if (cmd.grow_step) begin
        gsz_r <= gsz_r + 7'd1; size_r <= gsz_r + 7'd1;
      end else if (cmd.size_load) begin
        size_r <= 7'(keep_n_r) + 7'(cmd.scan_keep);
        gsz_r <= 7'(keep_n_r) + 7'(cmd.scan_keep);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.scan_clr) keep_n_r <= '0;
    else if (cmd.scan_keep) keep_n_r <= keep_n_r + 7'd1;
  end
endmodule

// ===== rtl/core/segment_signature_average_table.sv =====
// Segment signature averaging table, top level.
// Input words on in_valid/in_ready: op 0 updates or grows a slot, op 1 prunes.
// Result words on out_valid/out_ready, last marks the final word of an item.
// An update grows the table one slot per cycle, then reads the entry; with the
// segment present a 28 step radix-2 divider per field averages the six fields.
// A prune runs a max scan and then a compare and compact pass over the slots,
// then emits each kept slot as a word; an empty prune gives one empty word.
// One item is handled at a time; the next is taken in the cycle after the last
// word left.
// Reset clears the table size and sets keep_fraction to half; entry
// contents are only read after being written by a grow.
// A stalled receiver holds the output register and pauses the block.
// keep_fraction is written by cfg_we with cfg_data; write it only while idle (not enforced).
// The output register holds its word until out_ready is seen high.
`include "segment_signature_average_table_defines.svh"
module segment_signature_average_table #(
  parameter int NODE_SLOTS = ssat_pkg::NodeSlotsDef
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  logic in_op,
  input  logic [5:0] in_node_index,
  input  logic in_present,
  input  logic [19:0] in_seg_area,
  input  logic [7:0] in_seg_red,
  input  logic [7:0] in_seg_green,
  input  logic [7:0] in_seg_blue,
  input  logic [11:0] in_seg_center_x,
  input  logic [11:0] in_seg_center_y,
  output logic out_valid,
  input  logic out_ready,
  output logic [1:0] out_kind,
  output logic [5:0] out_slot,
  output logic [15:0] out_seen_count,
  output logic [27:0] out_avg_area,
  output logic [15:0] out_avg_red,
  output logic [15:0] out_avg_green,
  output logic [15:0] out_avg_blue,
  output logic [19:0] out_avg_center_x,
  output logic [19:0] out_avg_center_y,
  output logic out_last,
  input  logic cfg_we,
  input  logic [15:0] cfg_data
);
  logic [15:0] keep_r;
  ssat_pkg::cmd_t cmd;
  ssat_pkg::sts_t sts;
  logic [5:0] addr;
  logic [6:0] size;

  always_ff @(posedge clk) begin
    if (!rst_n) keep_r <= ssat_pkg::KeepReset;
    else if (cfg_we) keep_r <= cfg_data;
  end

  ssat_ctrl #(.NODE_SLOTS(NODE_SLOTS)) u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .in_op, .in_present, .out_ready,
    .out_valid, .size, .sts, .cmd, .addr
  );

  ssat_dp #(.NODE_SLOTS(NODE_SLOTS)) u_dp (
    .clk, .rst_n, .cmd, .sts, .addr, .size, .keep_fraction(keep_r),
    .in_node_index, .in_seg_area, .in_seg_red, .in_seg_green, .in_seg_blue,
    .in_seg_center_x, .in_seg_center_y, .out_kind, .out_slot, .out_seen_count,
    .out_avg_area, .out_avg_red, .out_avg_green, .out_avg_blue,
    .out_avg_center_x, .out_avg_center_y, .out_last
  );

  `SSAT_ASSERT_IMPL(a_busy_no_accept, clk, rst_n, out_valid, !in_ready)
  `SSAT_ASSERT_IMPL(a_size_bound, clk, rst_n, 1'b1, size <= 7'(NODE_SLOTS))
  `SSAT_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid)
endmodule

// ===== verif/tb_segment_signature_average_table.sv =====
// testbench for segment_signature_average_table: random and directed updates and prunes,
// results checked against an in-bench table model; depends on ssat_pkg and the rtl
`timescale 1ns / 100ps
module tb_segment_signature_average_table;

  typedef struct packed {
    logic op;
    logic [5:0] node_index;
    logic present;
    logic [19:0] seg_area;
    logic [7:0] seg_red;
    logic [7:0] seg_green;
    logic [7:0] seg_blue;
    logic [11:0] seg_center_x;
    logic [11:0] seg_center_y;
  } seg_word_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [5:0] slot;
    logic [15:0] seen_count;
    logic [27:0] avg_area;
    logic [15:0] avg_red;
    logic [15:0] avg_green;
    logic [15:0] avg_blue;
    logic [19:0] avg_center_x;
    logic [19:0] avg_center_y;
    logic last;
  } sig_word_t;

  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_PRUNE = 1'b1;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_ready;
  seg_word_t in_w = '0;
  logic out_valid;
  logic out_ready = 0;
  sig_word_t out_w;
  logic cfg_we = 0;
  logic [15:0] cfg_data = 0;

  seg_word_t pending_words[$];
  sig_word_t expected_sigs[$];
  int errors = 0;
  int in_gap = 0;
  int out_gap = 0;
  logic stim_done = 0;

  logic [27:0] t_area[64];
  logic [15:0] t_red[64], t_green[64], t_blue[64], t_cnt[64];
  logic [19:0] t_cx[64], t_cy[64];
  int t_size;
  logic [15:0] m_keep;

  segment_signature_average_table dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_op(in_w.op), .in_node_index(in_w.node_index), .in_present(in_w.present),
    .in_seg_area(in_w.seg_area), .in_seg_red(in_w.seg_red),
    .in_seg_green(in_w.seg_green), .in_seg_blue(in_w.seg_blue),
    .in_seg_center_x(in_w.seg_center_x), .in_seg_center_y(in_w.seg_center_y),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_kind(out_w.kind), .out_slot(out_w.slot), .out_seen_count(out_w.seen_count),
    .out_avg_area(out_w.avg_area), .out_avg_red(out_w.avg_red),
    .out_avg_green(out_w.avg_green), .out_avg_blue(out_w.avg_blue),
    .out_avg_center_x(out_w.avg_center_x), .out_avg_center_y(out_w.avg_center_y),
    .out_last(out_w.last),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic logic [31:0] weighted_mean(logic [31:0] s, logic [15:0] c,
                                                logic [31:0] v);
    logic [63:0] num;
    num = 64'(s) * 64'(c) + (64'(v) << 8);
    return 32'(num / (64'(c) + 64'd1));
  endfunction

  function automatic sig_word_t entry_sig(logic [1:0] k, int slot, int src, logic lst);
    sig_word_t r;
    r.kind = k;
    r.slot = slot[5:0];
    r.seen_count = t_cnt[src];
    r.avg_area = t_area[src];
    r.avg_red = t_red[src];
    r.avg_green = t_green[src];
    r.avg_blue = t_blue[src];
    r.avg_center_x = t_cx[src];
    r.avg_center_y = t_cy[src];
    r.last = lst;
    return r;
  endfunction

  task automatic predict_table(seg_word_t w);
    int idx, n;
    logic [15:0] c, longest;
    logic [47:0] thr;
    sig_word_t r;
    if (w.op == OP_UPDATE) begin
      idx = w.node_index;
      while (t_size <= idx) begin
        t_area[t_size] = '0; t_red[t_size] = '0; t_green[t_size] = '0;
        t_blue[t_size] = '0; t_cx[t_size] = '0; t_cy[t_size] = '0; t_cnt[t_size] = '0;
        t_size++;
      end
      if (w.present) begin
        c = t_cnt[idx];
        t_area[idx] = 28'(weighted_mean(32'(t_area[idx]), c, 32'(w.seg_area)));
        t_red[idx] = 16'(weighted_mean(32'(t_red[idx]), c, 32'(w.seg_red)));
        t_green[idx] = 16'(weighted_mean(32'(t_green[idx]), c, 32'(w.seg_green)));
        t_blue[idx] = 16'(weighted_mean(32'(t_blue[idx]), c, 32'(w.seg_blue)));
        t_cx[idx] = 20'(weighted_mean(32'(t_cx[idx]), c, 32'(w.seg_center_x)));
        t_cy[idx] = 20'(weighted_mean(32'(t_cy[idx]), c, 32'(w.seg_center_y)));
        if (c != ssat_pkg::CountMax) t_cnt[idx] = c + 16'd1;
      end
      expected_sigs = {expected_sigs, entry_sig(ssat_pkg::KIND_UPDATE, idx, idx, 1'b1)};
    end else if (t_size == 0) begin
      r = '0;
      r.kind = ssat_pkg::KIND_EMPTY;
      r.last = 1'b1;
      expected_sigs = {expected_sigs, r};
    end else begin
      longest = '0;
      for (int i = 0; i < t_size; i++) if (t_cnt[i] > longest) longest = t_cnt[i];
      thr = 48'(longest) * 48'(m_keep);
      n = 0;
      for (int i = 0; i < t_size; i++) begin
        if ((48'(t_cnt[i]) << 16) >= thr) begin
          t_area[n] = t_area[i]; t_red[n] = t_red[i]; t_green[n] = t_green[i];
          t_blue[n] = t_blue[i]; t_cx[n] = t_cx[i]; t_cy[n] = t_cy[i];
          t_cnt[n] = t_cnt[i];
          n++;
        end
      end
      t_size = n;
      for (int i = 0; i < n; i++)
        expected_sigs = {expected_sigs, entry_sig(ssat_pkg::KIND_KEPT, i, i, i == n - 1)};
    end
  endtask

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 45) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        predict_table(in_w);
        if (pending_words.size() > 0 && in_gap == 0) begin
          in_w <= pending_words.pop_front();
          in_gap = pick_gap();
        end else begin
          in_valid <= 0;
        end
      end else if (!in_valid) begin
        if (in_gap > 0) in_gap--;
        else if (pending_words.size() > 0) begin
          in_w <= pending_words.pop_front();
          in_valid <= 1;
          in_gap = pick_gap();
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_sigs.size() == 0) begin
          $display("%0t unexpected word %p", $time, out_w);
          errors++;
        end else begin
          sig_word_t e;
          e = expected_sigs.pop_front();
          if (e !== out_w) begin
            $display("%0t expected %p", $time, e);
            $display("%0t actual   %p", $time, out_w);
            errors++;
          end
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_ready <= 0;
      end else begin
        out_ready <= 1;
        if ($urandom_range(0, 3) == 0) out_gap = pick_gap();
      end
    end
  end

  function automatic seg_word_t rand_update(int max_idx, int present_pct);
    seg_word_t w;
    w = seg_word_t'(76'({$urandom, $urandom, $urandom}));
    w.op = OP_UPDATE;
    w.node_index = 6'($urandom_range(0, max_idx));
    w.present = $urandom_range(0, 99) < present_pct;
    return w;
  endfunction

  task automatic run_phase(input int n);
    int r;
    seg_word_t w;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        w = seg_word_t'(76'({$urandom, $urandom, $urandom}));
        w.op = OP_PRUNE;
      end else begin
        w = rand_update(r < 20 ? 63 : 11, 85);
      end
      pending_words = {pending_words, w};
    end
  endtask

  task automatic settle_and_config(logic [15:0] v);
    while (pending_words.size() > 0 || in_valid || expected_sigs.size() > 0)
      @(posedge clk);
    repeat (300) @(posedge clk);
    cfg_data <= v;
    cfg_we <= 1;
    @(posedge clk);
    cfg_we <= 0;
    m_keep = v;
  endtask

  initial begin
    seg_word_t w;
    t_size = 0;
    m_keep = ssat_pkg::KeepReset;
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: empty prune, extremes, not present, top slot, prune
    w = '0; w.op = OP_PRUNE; pending_words = {pending_words, w};
    w = '0; w.present = 0; w.node_index = 2; pending_words = {pending_words, w};
    w = '1; w.op = OP_UPDATE; w.node_index = 0; pending_words = {pending_words, w};
    w = '1; w.op = OP_UPDATE; w.node_index = 0; pending_words = {pending_words, w};
    w = '0; w.present = 1; w.node_index = 0; pending_words = {pending_words, w};
    w = '0; w.present = 1; w.node_index = 1; pending_words = {pending_words, w};
    w = '1; w.op = OP_UPDATE; w.node_index = 63; pending_words = {pending_words, w};
    w = '0; w.present = 0; w.node_index = 5; pending_words = {pending_words, w};
    w = '1; w.op = OP_PRUNE; pending_words = {pending_words, w};
    w = '0; w.op = OP_PRUNE; pending_words = {pending_words, w};
    settle_and_config(16'h0000);
    // zero fraction keeps every entry, also with all counts zero
    w = '0; w.node_index = 4; pending_words = {pending_words, w};
    w = '0; w.op = OP_PRUNE; pending_words = {pending_words, w};
    settle_and_config(16'hFFFF);
    for (int i = 0; i < 3; i++) pending_words = {pending_words, rand_update(3, 100)};
    w = '0; w.op = OP_PRUNE; pending_words = {pending_words, w};
    run_phase(25);
    settle_and_config(16'h4000);
    run_phase(35);
    settle_and_config(16'(($urandom_range(0, 65535))));
    run_phase(25);
    settle_and_config(ssat_pkg::KeepReset);
    run_phase(10);
    while (pending_words.size() > 0 || in_valid || expected_sigs.size() > 0)
      @(posedge clk);
    repeat (300) @(posedge clk);
    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #40ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/ssat_pkg.sv
rtl/core/ssat_ctrl.sv
rtl/core/ssat_dp.sv
rtl/core/segment_signature_average_table.sv
verif/tb_segment_signature_average_table.sv
